FILE: hw/rtl/positional_list_insert_remove_assert.svh
// Assertion macros shared by the positional list RTL.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list: implication check failed");

// Next-cycle implication, disabled during reset.
`define PLI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list: next-cycle check failed");

`endif

FILE: hw/rtl/pli_pkg.sv
// Shared constants and types of the positional list.
`default_nettype none

package pli_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W  = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic load;
    logic insert;
    logic remove;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_list_insert_remove.sv
// Top level of the positional list: request decode, cell row, result collection.
//
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells,
// one entry per cell. A request is accepted when the block is idle; all cells
// shift in the same cycle, and a removed entry is gathered through a registered
// OR tree of clog2(CAPACITY) levels. The result is valid once the entry has passed
// the cell tap registers and every tree level; no new request is taken until the
// result is taken, and the next request can be taken in the cycle after that.
// entry_count reports the count masked to 7 bits. No clearing pass is needed
// after reset.
`default_nettype none

module positional_list_insert_remove #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic        [pli_pkg::OP_W-1:0]  opcode,
  input  wire logic        [pli_pkg::POS_W-1:0] position,
  input  wire logic signed [pli_pkg::VAL_W-1:0] value,
  output logic                                 res_valid,
  input  wire logic                            res_stall,
  output logic signed      [pli_pkg::VAL_W-1:0] removed_value,
  output logic             [pli_pkg::ST_W-1:0]  status,
  output logic             [pli_pkg::CNT_W-1:0] entry_count
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = CW + pli_pkg::POS_W;
  localparam int LAT = $clog2(CAPACITY);
  localparam int WW  = $clog2(LAT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                    state;
  logic [WW-1:0]             wait_cnt;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [pli_pkg::ST_W-1:0]  status_next;
  logic                      accept;
  logic                      ins_ok;
  logic                      rem_ok;
  logic [IW-1:0]             pos_ext;
  logic [IW-1:0]             cnt_ext;
  logic [IW-1:0]             cnt_wide;
  pli_pkg::cmd_t             cmd;
  logic [pli_pkg::VAL_W-1:0] cell_data [CAPACITY];
  logic [pli_pkg::VAL_W-1:0] cell_tap  [CAPACITY];
  logic [pli_pkg::VAL_W-1:0] root;

  assign req_stall = rst || (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign accept    = req_valid && !req_stall;

  assign pos_ext  = {{CW{1'b0}}, position};
  assign cnt_ext  = {{pli_pkg::POS_W{1'b0}}, count};
  assign cnt_wide = {{pli_pkg::POS_W{1'b0}}, count};

  always_comb begin
    status_next = pli_pkg::ST_OK;
    count_next  = count;
    ins_ok      = 1'b0;
    rem_ok      = 1'b0;
    case (opcode)
      pli_pkg::OP_INSERT: begin
        if (count == CW'(CAPACITY)) begin
          status_next = pli_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_next = pli_pkg::ST_RANGE;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      pli_pkg::OP_REMOVE: begin
        if (count == '0) begin
          status_next = pli_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = pli_pkg::ST_RANGE;
        end else begin
          rem_ok     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      pli_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd = '{load: accept, insert: ins_ok, remove: rem_ok};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pli_pkg::VAL_W-1:0] prev_data;
    logic [pli_pkg::VAL_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = value;
    end else begin : g_mid_prev
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid_next
      assign next_data = cell_data[i+1];
    end

    pli_cell #(
      .INDEX(i),
      .IW   (IW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (pos_ext),
      .value    (value),
      .prev_data(prev_data),
      .next_data(next_data),
      .data     (cell_data[i]),
      .tap      (cell_tap[i])
    );
  end

  pli_or_tree #(
    .W(pli_pkg::VAL_W),
    .N(CAPACITY)
  ) u_tree (
    .clk (clk),
    .leaf(cell_tap),
    .root(root)
  );

  assign removed_value = root;
  assign entry_count   = cnt_wide[pli_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wait_cnt <= '0;
      count    <= '0;
      status   <= pli_pkg::ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_WAIT;
            wait_cnt <= WW'(LAT - 1);
            count    <= count_next;
            status   <= status_next;
          end
        end
        S_WAIT: begin
          if (wait_cnt == '0) begin
            state <= S_DONE;
          end else begin
            wait_cnt <= wait_cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (!res_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "positional_list_insert_remove_assert.svh"

  `PLI_ASSERT_IMPLY(a_no_accept_pending, clk, rst, res_valid, req_stall)
  `PLI_ASSERT_NEXT(a_result_not_same_cycle, clk, rst, accept, !res_valid)
  `PLI_ASSERT_NEXT(a_insert_counts_up, clk, rst, accept && ins_ok, count == $past(count) + 1'b1)
  `PLI_ASSERT_IMPLY(a_value_only_on_ok, clk, rst,
                    res_valid && (removed_value != '0), status == pli_pkg::ST_OK)

endmodule

`default_nettype wire

FILE: hw/rtl/pli_cell.sv
// One list cell: holds one entry and shifts with its neighbors.
`default_nettype none

module pli_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 14
) (
  input  wire logic                     clk,
  input  wire pli_pkg::cmd_t            cmd,
  input  wire logic [IW-1:0]            pos,
  input  wire logic [pli_pkg::VAL_W-1:0] value,
  input  wire logic [pli_pkg::VAL_W-1:0] prev_data,
  input  wire logic [pli_pkg::VAL_W-1:0] next_data,
  output logic      [pli_pkg::VAL_W-1:0] data,
  output logic      [pli_pkg::VAL_W-1:0] tap
);

  logic hit;
  logic after;

  assign hit   = (pos == IW'(INDEX));
  assign after = (pos < IW'(INDEX));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.insert) begin
        if (hit) begin
          data <= value;
        end else if (after) begin
          data <= prev_data;
        end
      end else if (cmd.remove && (hit || after)) begin
        data <= next_data;
      end
      tap <= (cmd.remove && hit) ? data : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pli_or_tree.sv
// Registered OR tree that collects the tapped entry from the cell row.
`default_nettype none

module pli_or_tree #(
  parameter int W = 32,
  parameter int N = 64
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] leaf [N],
  output logic      [W-1:0] root
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
  localparam int P      = 1 << LEVELS;

  logic [W-1:0] node [P-1];

  for (genvar k = 0; k < P - 1; k++) begin : g_node
    logic [W-1:0] lhs;
    logic [W-1:0] rhs;

    if (2 * k + 1 < P - 1) begin : g_lhs_node
      assign lhs = node[2*k+1];
    end else if (2 * k + 1 - (P - 1) < N) begin : g_lhs_leaf
      assign lhs = leaf[2*k+1-(P-1)];
    end else begin : g_lhs_pad
      assign lhs = '0;
    end

    if (2 * k + 2 < P - 1) begin : g_rhs_node
      assign rhs = node[2*k+2];
    end else if (2 * k + 2 - (P - 1) < N) begin : g_rhs_leaf
      assign rhs = leaf[2*k+2-(P-1)];
    end else begin : g_rhs_pad
      assign rhs = '0;
    end

    always_ff @(posedge clk) begin
      node[k] <= lhs | rhs;
    end
  end

  assign root = node[0];

endmodule

`default_nettype wire

FILE: verif/positional_list_insert_remove_tb.sv
// Self-checking testbench for the positional list: queued requests, predicted results.
module positional_list_insert_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = pli_pkg::CAPACITY_DEF;
  localparam int RANDOM_REQS  = 1800;
  localparam int HOLDOFF_AT   = 600;
  localparam int HOLDOFF_LEN  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [pli_pkg::OP_W-1:0]         op_t;
  typedef logic [pli_pkg::POS_W-1:0]        pos_t;
  typedef logic signed [pli_pkg::VAL_W-1:0] val_t;
  typedef logic [pli_pkg::ST_W-1:0]         st_t;
  typedef logic [pli_pkg::CNT_W-1:0]        cnt_t;

  localparam op_t OP_NOP = 2'd3;

  typedef struct packed {
    op_t  op;
    pos_t pos;
    val_t val;
  } list_req_t;

  typedef struct packed {
    val_t removed;
    st_t  status;
    cnt_t entry_cnt;
  } list_result_t;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  op_t   opcode;
  pos_t  position;
  val_t  value;
  logic  res_valid;
  logic  res_stall;
  val_t  removed_value;
  st_t   status;
  cnt_t  entry_count;

  list_req_t    pending_q[$];
  list_result_t expected_q[$];
  list_req_t    next_req;
  list_result_t want;

  val_t list_mem [CAP];
  int   list_len;

  int burst_left;
  int gap_left;
  int phase_left;
  int hold_left;
  bit holdoff_done;
  int results_seen;
  int fail_count;
  int cycle_count;

  positional_list_insert_remove #(.CAPACITY(CAP)) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .opcode        (opcode),
    .position      (position),
    .value         (value),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .removed_value (removed_value),
    .status        (status),
    .entry_count   (entry_count)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_list_request(op_t op, pos_t pos, val_t val);
    list_result_t r;
    int p;
    int i;
    r.removed = '0;
    r.status  = pli_pkg::ST_OK;
    p = int'(pos);
    case (op)
      pli_pkg::OP_INSERT: begin
        if (list_len >= CAP) begin
          r.status = pli_pkg::ST_FULL;
        end else if (p > list_len) begin
          r.status = pli_pkg::ST_RANGE;
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_len++;
        end
      end
      pli_pkg::OP_REMOVE: begin
        if (list_len == 0) begin
          r.status = pli_pkg::ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = pli_pkg::ST_RANGE;
        end else begin
          r.removed = list_mem[p];
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      pli_pkg::OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.entry_cnt = cnt_t'(list_len);
    return r;
  endfunction

  task automatic add_req(op_t op, pos_t pos, val_t val);
    list_req_t q;
    q.op  = op;
    q.pos = pos;
    q.val = val;
    pending_q.push_back(q);
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(19))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      opcode     <= pli_pkg::OP_INSERT;
      position   <= '0;
      value      <= '0;
      burst_left <= 0;
      gap_left   <= 0;
      list_len   = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_q.push_back(apply_list_request(opcode, position, value));
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          next_req  = pending_q.pop_front();
          opcode    <= next_req.op;
          position  <= next_req.pos;
          value     <= next_req.val;
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall    <= 1'b0;
      phase_left   <= 0;
      hold_left    <= 0;
      holdoff_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      hold_left    <= HOLDOFF_LEN;
      res_stall    <= 1'b1;
    end else if (phase_left > 0) begin
      phase_left <= phase_left - 1;
    end else if ($urandom_range(9) < 5) begin
      res_stall  <= 1'b0;
      phase_left <= $urandom_range(0, 40);
    end else begin
      res_stall  <= 1'b1;
      phase_left <= $urandom_range(0, 7);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
    end else if (res_valid && !res_stall) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: removed_value=%0d status=%0d entry_count=%0d",
               removed_value, status, entry_count);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (removed_value !== want.removed) begin
          $error("removed_value: expected %0d, got %0d", want.removed, removed_value);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (entry_count !== want.entry_cnt) begin
          $error("entry_count: expected %0d, got %0d", want.entry_cnt, entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int   gen_len;
    int   n;
    int   r;
    bit   filling;
    op_t  op;
    pos_t pos;

    fail_count = 0;
    rst        <= 1'b1;

    add_req(pli_pkg::OP_REMOVE, 7'd0,   32'sd5);
    add_req(pli_pkg::OP_REMOVE, 7'd127, 32'sd5);
    add_req(pli_pkg::OP_CLEAR,  7'd0,   32'sd0);
    add_req(OP_NOP,             7'd0,   32'sd0);
    add_req(pli_pkg::OP_INSERT, 7'd1,   32'sd9);
    add_req(pli_pkg::OP_INSERT, 7'd0,   32'sh8000_0000);
    add_req(pli_pkg::OP_INSERT, 7'd1,   32'sh7fff_ffff);
    add_req(pli_pkg::OP_INSERT, 7'd0,   -32'sd1);
    add_req(pli_pkg::OP_INSERT, 7'd1,   32'sh5555_5555);
    add_req(pli_pkg::OP_INSERT, 7'd4,   32'shaaaa_aaaa);
    add_req(pli_pkg::OP_INSERT, 7'd127, 32'sd3);
    add_req(pli_pkg::OP_INSERT, 7'd6,   32'sd3);
    add_req(pli_pkg::OP_REMOVE, 7'd5,   32'sd0);
    add_req(pli_pkg::OP_REMOVE, 7'd127, 32'sd0);
    add_req(pli_pkg::OP_REMOVE, 7'd3,   32'sd0);
    add_req(pli_pkg::OP_REMOVE, 7'd0,   32'sd0);
    add_req(OP_NOP,             7'd127, -32'sd1);
    add_req(pli_pkg::OP_REMOVE, 7'd2,   32'sd0);
    add_req(pli_pkg::OP_CLEAR,  7'd127, -32'sd1);
    add_req(pli_pkg::OP_REMOVE, 7'd0,   32'sd0);
    add_req(pli_pkg::OP_INSERT, 7'd0,   32'sd42);
    add_req(pli_pkg::OP_CLEAR,  7'd0,   32'sd0);
    gen_len = 0;

    // random walk between empty and full, mostly well-formed
    filling = 1'b1;
    for (n = 0; n < RANDOM_REQS; n++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        op = pli_pkg::OP_CLEAR;
        pos = pos_t'($urandom_range(127));
      end else if (r < 5) begin
        op = OP_NOP;
        pos = pos_t'($urandom_range(127));
      end else if (r < 10) begin
        op = ($urandom_range(1) == 0) ? pli_pkg::OP_INSERT : pli_pkg::OP_REMOVE;
        pos = pos_t'($urandom_range(127));
      end else begin
        if (filling) begin
          op = ($urandom_range(3) != 0) ? pli_pkg::OP_INSERT : pli_pkg::OP_REMOVE;
        end else begin
          op = ($urandom_range(3) != 0) ? pli_pkg::OP_REMOVE : pli_pkg::OP_INSERT;
        end
        if (op == pli_pkg::OP_INSERT) pos = pos_t'($urandom_range(gen_len));
        else pos = (gen_len > 0) ? pos_t'($urandom_range(gen_len - 1)) : '0;
      end
      add_req(op, pos, pick_value());
      case (op)
        pli_pkg::OP_INSERT: if (gen_len < CAP && int'(pos) <= gen_len) gen_len++;
        pli_pkg::OP_REMOVE: if (gen_len > 0 && int'(pos) < gen_len) gen_len--;
        pli_pkg::OP_CLEAR:  gen_len = 0;
        default: ;
      endcase
      if (filling && gen_len == CAP && $urandom_range(2) == 0) filling = 1'b0;
      else if (!filling && gen_len == 0 && $urandom_range(2) == 0) filling = 1'b1;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || req_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
